>>> rtl/core/cvas_pkg.sv
// Package of the closest view angle select block: shared types and constants.
// Used by every module under rtl/core; it depends on nothing.
package cvas_pkg;

  // Fixed widths of the coordinate, cosine and index fields and of the arithmetic intermediates.
  localparam int unsigned CoordW  = 32;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned SmallW  = 15;
  localparam int unsigned CosW    = 15;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned SqW     = 30;
  localparam int unsigned ProdW   = 2 * SqW;
  localparam int unsigned QuotW   = 16;
  localparam int unsigned CfgIdxW = 3;

  // Saturation value of the cosine and reset value of the minimum cosine, Q0.15.
  localparam logic [CosW-1:0] CosMax = 15'h7FFF;
  localparam logic [CosW-1:0] MinCosReset = 15'd16384;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPointX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPointY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPointZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegQueryX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegQueryY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegQueryZ = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMinCos = 3'd6;

  // Geometry taken from configuration by the front.
  typedef struct packed {
    logic signed [2:0][CoordW-1:0] point;
    logic signed [2:0][CoordW-1:0] query;
  } geom_t;

  // One classified observation handed from front to back.
  typedef struct packed {
    logic [CosW-1:0] cosine;
    logic            last;
  } obs_t;

  // Front sequencer states.
  typedef enum logic [2:0] {
    FrIdle,
    FrScale,
    FrMac,
    FrProd,
    FrSqrt,
    FrDiv,
    FrPush
  } front_state_e;

endpackage

>>> rtl/core/closest_view_angle_select_top.sv
// Closest view angle select: of a stream of camera positions, finds the one
// whose view of a configured point is nearest the query camera's direction.
// Top level; instantiates cvas_front, cvas_queue and cvas_back; uses cvas_pkg.
//
// Each camera position occupies the front from its transfer on: a scaling check
// with serial shifts, the nine-step shared multiplier and the product step,
// then, unless a vector has zero length or the dot product is not positive,
// the digit-by-digit square root, the restoring divider and forming the cosine;
// the push state then hands it to the queue and waits while the queue is full.
// A new item is taken only once the front is idle. The back compares each
// popped entry against the running maximum, and a two-entry queue plus the
// result register let the front keep working while a result waits. A result
// appears only for an item with tlast set.
module closest_view_angle_select_top #(
  parameter int unsigned MaxObs = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cam_x [31:0], cam_y [63:32], cam_z [95:64]
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // best_index [5:0], best_found [6], accepted [7], best_cosine [22:8], zero [23]
  output logic [23:0] m_axis_tdata
);

  cvas_pkg::geom_t           geom_q;
  logic [cvas_pkg::CosW-1:0] min_cos_q;
  logic                      push_valid, push_ready, pop_valid, pop_ready;
  cvas_pkg::obs_t            push_data, pop_data;
  logic [5:0]                res_index;
  logic                      res_found, res_accept;
  logic [cvas_pkg::CosW-1:0] res_cos;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q    <= '0;
      min_cos_q <= cvas_pkg::MinCosReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cvas_pkg::RegPointX: geom_q.point[0] <= cfg_wdata_i;
        cvas_pkg::RegPointY: geom_q.point[1] <= cfg_wdata_i;
        cvas_pkg::RegPointZ: geom_q.point[2] <= cfg_wdata_i;
        cvas_pkg::RegQueryX: geom_q.query[0] <= cfg_wdata_i;
        cvas_pkg::RegQueryY: geom_q.query[1] <= cfg_wdata_i;
        cvas_pkg::RegQueryZ: geom_q.query[2] <= cfg_wdata_i;
        cvas_pkg::RegMinCos: min_cos_q <= cfg_wdata_i[cvas_pkg::CosW-1:0];
        default: begin
        end
      endcase
    end
  end

  cvas_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cam_x_i      (s_axis_tdata[31:0]),
    .cam_y_i      (s_axis_tdata[63:32]),
    .cam_z_i      (s_axis_tdata[95:64]),
    .last_i       (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  cvas_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  cvas_back #(
    .MaxObs (MaxObs)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_cos_i    (min_cos_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_index_o  (res_index),
    .res_found_o  (res_found),
    .res_accept_o (res_accept),
    .res_cos_o    (res_cos)
  );

  assign m_axis_tdata = {1'b0, res_cos, res_accept, res_found, res_index};

  // With nothing found the index and cosine are zero.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_found) |-> (res_index == '0 && res_cos == '0))
    else $error("result without a find carries a nonzero index or cosine");

  // A find always carries a positive cosine.
  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_found) |-> (res_cos != '0))
    else $error("found result with zero cosine");

  // The front never offers an entry into a full queue without holding it.
  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && !push_ready) |=> (push_valid && $stable(push_data)))
    else $error("front dropped an entry while the queue was full");

endmodule

>>> rtl/core/cvas_front.sv
// Front of the closest view angle select block: takes one camera position and
// works out its Q0.15 cosine over several cycles. Depends on cvas_pkg.
module cvas_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cvas_pkg::geom_t                    geom_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cvas_pkg::CoordW-1:0] cam_x_i,
  input  logic signed [cvas_pkg::CoordW-1:0] cam_y_i,
  input  logic signed [cvas_pkg::CoordW-1:0] cam_z_i,
  input  logic                               last_i,
  output logic                               push_valid_o,
  input  logic                               push_ready_i,
  output cvas_pkg::obs_t                     push_data_o
);

  localparam int unsigned DW = cvas_pkg::DiffW;
  localparam int unsigned SW = cvas_pkg::SmallW;
  localparam int unsigned QW = cvas_pkg::SqW;
  localparam int unsigned PW = cvas_pkg::ProdW;

  cvas_pkg::front_state_e state_q, state_d;

  logic [2:0][DW-1:0]  ma_q, mb_q;
  logic [2:0]          na_q, nb_q;
  logic                last_q;
  logic [3:0]          step_q;
  logic [QW-1:0]       acc_a_q, acc_b_q;
  logic signed [QW:0]  acc_d_q;
  logic [PW-1:0]       rad_q, root_q;
  logic [4:0]          sq_k_q;
  logic [QW:0]         rem_q;
  logic [cvas_pkg::QuotW-1:0] num_q, quo_q;
  logic [cvas_pkg::CosW-1:0]  cos_q;

  logic [2:0][DW-1:0]  diff_a, diff_b;
  logic [2:0]          big_a, big_b;
  logic [2:0][SW-1:0]  sa, sb;
  logic signed [SW-1:0] op1, op2;
  logic signed [2*SW-1:0] prod;
  logic                degen;
  logic [PW-1:0]       sq_bit, sq_trial;
  logic [QW:0]         rem_sh;
  logic [PW-1:0]       root_ext;

  // Differences to the point, sign-magnitude form, and scaling tests.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [DW-1:0] da, db;
      da = DW'(signed'(geom_i.query[i])) - DW'(signed'(geom_i.point[i]));
      db = DW'(signed'(i == 0 ? cam_x_i : (i == 1 ? cam_y_i : cam_z_i)))
           - DW'(signed'(geom_i.point[i]));
      diff_a[i] = da;
      diff_b[i] = db;
      big_a[i] = |ma_q[i][DW-1:SW-1];
      big_b[i] = |mb_q[i][DW-1:SW-1];
      sa[i] = na_q[i] ? SW'(-ma_q[i]) : SW'(ma_q[i]);
      sb[i] = nb_q[i] ? SW'(-mb_q[i]) : SW'(mb_q[i]);
    end
  end

  // Shared multiplier: squares of a, squares of b, then a.b.
  always_comb begin
    unique case (step_q)
      4'd0: begin op1 = sa[0]; op2 = sa[0]; end
      4'd1: begin op1 = sa[1]; op2 = sa[1]; end
      4'd2: begin op1 = sa[2]; op2 = sa[2]; end
      4'd3: begin op1 = sb[0]; op2 = sb[0]; end
      4'd4: begin op1 = sb[1]; op2 = sb[1]; end
      4'd5: begin op1 = sb[2]; op2 = sb[2]; end
      4'd6: begin op1 = sa[0]; op2 = sb[0]; end
      4'd7: begin op1 = sa[1]; op2 = sb[1]; end
      default: begin op1 = sa[2]; op2 = sb[2]; end
    endcase
    prod = op1 * op2;
  end

  assign degen    = (acc_a_q == '0) || (acc_b_q == '0) || (acc_d_q <= 0);
  assign sq_bit   = PW'(1) << {sq_k_q, 1'b0};
  assign sq_trial = root_q + sq_bit;
  assign rem_sh   = {rem_q[QW-1:0], num_q[cvas_pkg::QuotW-1]};
  assign root_ext = root_q;

  // Handshake outputs; a cosine from the divider is formed in the first push cycle.
  always_comb begin
    in_ready_o   = (state_q == cvas_pkg::FrIdle);
    push_valid_o = (state_q == cvas_pkg::FrPush) && (step_q != 4'd0);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cvas_pkg::FrIdle:  if (in_valid_i) state_d = cvas_pkg::FrScale;
      cvas_pkg::FrScale: if (!(|big_a) && !(|big_b)) state_d = cvas_pkg::FrMac;
      cvas_pkg::FrMac:   if (step_q == 4'd8) state_d = cvas_pkg::FrProd;
      cvas_pkg::FrProd:  state_d = degen ? cvas_pkg::FrPush : cvas_pkg::FrSqrt;
      cvas_pkg::FrSqrt:  if (sq_k_q == '0) state_d = cvas_pkg::FrDiv;
      cvas_pkg::FrDiv:   if (step_q == 4'd15) state_d = cvas_pkg::FrPush;
      cvas_pkg::FrPush:  if (push_valid_o && push_ready_i) state_d = cvas_pkg::FrIdle;
      default:           state_d = cvas_pkg::FrIdle;
    endcase
  end

  assign push_data_o = '{cosine: cos_q, last: last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cvas_pkg::FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers, loaded per sequencer step.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cvas_pkg::FrIdle: begin
        for (int i = 0; i < 3; i++) begin
          na_q[i] <= diff_a[i][DW-1];
          nb_q[i] <= diff_b[i][DW-1];
          ma_q[i] <= diff_a[i][DW-1] ? -diff_a[i] : diff_a[i];
          mb_q[i] <= diff_b[i][DW-1] ? -diff_b[i] : diff_b[i];
        end
        last_q  <= last_i;
        step_q  <= '0;
        acc_a_q <= '0;
        acc_b_q <= '0;
        acc_d_q <= '0;
      end
      cvas_pkg::FrScale: begin
        for (int i = 0; i < 3; i++) begin
          if (|big_a) ma_q[i] <= ma_q[i] >> 1;
          if (|big_b) mb_q[i] <= mb_q[i] >> 1;
        end
      end
      cvas_pkg::FrMac: begin
        if (step_q < 4'd3) begin
          acc_a_q <= acc_a_q + QW'(unsigned'(prod));
        end else if (step_q < 4'd6) begin
          acc_b_q <= acc_b_q + QW'(unsigned'(prod));
        end else begin
          acc_d_q <= acc_d_q + (QW+1)'(prod);
        end
        step_q <= step_q + 4'd1;
      end
      cvas_pkg::FrProd: begin
        rad_q  <= acc_a_q * acc_b_q;
        root_q <= '0;
        sq_k_q <= 5'(QW - 1);
        cos_q  <= '0;
      end
      cvas_pkg::FrSqrt: begin
        // One result bit per cycle, digit-by-digit square root.
        if (rad_q >= sq_trial) begin
          rad_q  <= rad_q - sq_trial;
          root_q <= (root_q >> 1) + sq_bit;
        end else begin
          root_q <= root_q >> 1;
        end
        sq_k_q <= sq_k_q - 5'd1;
        rem_q  <= {1'b0, acc_d_q[QW:1]};
        num_q  <= {acc_d_q[0], 15'b0};
        step_q <= '0;
      end
      cvas_pkg::FrDiv: begin
        // Restoring division of D * 2^15 by the root, one quotient bit a cycle.
        if (rem_sh >= root_ext[QW:0]) begin
          rem_q <= rem_sh - root_ext[QW:0];
          quo_q <= {quo_q[cvas_pkg::QuotW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[cvas_pkg::QuotW-2:0], 1'b0};
        end
        num_q  <= num_q << 1;
        step_q <= step_q + 4'd1;
      end
      cvas_pkg::FrPush: begin
        if (step_q == 4'd0) begin
          cos_q  <= (root_q == '0) ? '0 :
                    (quo_q[cvas_pkg::QuotW-1] ? cvas_pkg::CosMax :
                     quo_q[cvas_pkg::CosW-1:0]);
          step_q <= 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/cvas_queue.sv
// Two-entry queue between front and back of the closest view angle select block.
// Depends on cvas_pkg for the entry type.
module cvas_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  cvas_pkg::obs_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output cvas_pkg::obs_t rd_data_o
);

  cvas_pkg::obs_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

>>> rtl/core/cvas_back.sv
// Back of the closest view angle select block: running maximum, index and the
// result register. Depends on cvas_pkg.
module cvas_back #(
  parameter int unsigned MaxObs = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cvas_pkg::CosW-1:0]   min_cos_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  cvas_pkg::obs_t              pop_data_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [cvas_pkg::IdxOutW-1:0] res_index_o,
  output logic                        res_found_o,
  output logic                        res_accept_o,
  output logic [cvas_pkg::CosW-1:0]   res_cos_o
);

  localparam int unsigned CntW = $clog2(MaxObs + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxObs);

  logic [cvas_pkg::CosW-1:0] max_q, max_d;
  logic [CntW-1:0]           idx_q, idx_d, cnt_q, cnt_d;
  logic                      have_q, have_d;
  logic                      res_valid_q;
  logic                      pop;

  assign pop_ready_o = !pop_data_i.last || !res_valid_q || res_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign res_valid_o = res_valid_q;

  // Compare against the running maximum; the earlier one wins a tie.
  always_comb begin
    max_d  = max_q;
    idx_d  = idx_q;
    have_d = have_q;
    cnt_d  = cnt_q;
    if (cnt_q < CntMax) begin
      if (pop_data_i.cosine > max_q) begin
        max_d  = pop_data_i.cosine;
        idx_d  = cnt_q;
        have_d = 1'b1;
      end
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '0;
      idx_q       <= '0;
      have_q      <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      if (pop) begin
        if (pop_data_i.last) begin
          max_q       <= '0;
          idx_q       <= '0;
          have_q      <= 1'b0;
          cnt_q       <= '0;
          res_valid_q <= 1'b1;
        end else begin
          max_q  <= max_d;
          idx_q  <= idx_d;
          have_q <= have_d;
          cnt_q  <= cnt_d;
        end
      end
    end
  end

  // Result register, loaded on the last observation of a search.
  always_ff @(posedge clk_i) begin
    if (pop && pop_data_i.last) begin
      res_index_o  <= have_d ? cvas_pkg::IdxOutW'(idx_d) : '0;
      res_found_o  <= have_d;
      res_accept_o <= (max_d >= min_cos_i);
      res_cos_o    <= max_d;
    end
  end

endmodule
